// ===== hdl/gms_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants and types of the group mean subtraction unit.
// Used by every module of the block; depends on nothing else.
package gms_pkg;

  // One sample on the input side and one deviation on the output side.
  localparam int DATA_W = 32;
  localparam int DEV_W  = 33;

  // Response plus eight regressor columns travel on the ports.
  localparam int FIELD_LANES = 9;
  localparam int IN_TDATA_W  = 288;
  localparam int OUT_TDATA_W = 304;

  // Column count register.
  localparam int              CFG_W     = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Flags that go out with each result word.
  typedef struct packed {
    logic last;
    logic ovf;
  } gms_flags_t;

endpackage

// ===== hdl/gms_row_store.sv =====
`timescale 1ns / 1ps
// Row buffer of the group mean subtraction unit: one write port, one read port.
// Read data is registered and holds while no read is issued. Uses gms_pkg.
module gms_row_store #(
  parameter int W  = 288,
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);
  import gms_pkg::*;

  logic [W-1:0] mem_r [2**AW];
  logic [W-1:0] rd_data_r;

  // Write side.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read side.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/gms_front.sv =====
`timescale 1ns / 1ps
// Front end of the group mean subtraction unit: takes input words, writes rows
// into the current buffer half, keeps column sums and hands finished groups on.
// Uses gms_pkg.
module gms_front #(
  parameter int MAX_ROWS = 64,
  parameter int LANES    = 9,
  parameter int SUM_W    = 38,
  parameter int CNT_W    = 7,
  parameter int AW       = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gms_pkg::IN_TDATA_W-1:0]    in_data,
  input  logic                              in_last,
  input  logic                              grp_done,
  output logic                              wr_en,
  output logic [AW-1:0]                     wr_addr,
  output logic [LANES*gms_pkg::DATA_W-1:0]  wr_data,
  output logic                              push,
  output logic [LANES*SUM_W-1:0]            job_sums,
  output logic [CNT_W-1:0]                  job_cnt,
  output logic                              job_ovf,
  output logic                              job_bank
);
  import gms_pkg::*;

  localparam int ROW_W = AW - 1;

  logic [CNT_W-1:0]       rows_r, rows_nxt;
  logic [LANES*SUM_W-1:0] sums_r, sums_nxt, sums_add;
  logic                   ovf_r, ovf_nxt;
  logic                   bank_r, bank_nxt;
  logic [1:0]             busy_r, busy_nxt;
  logic                   take;
  logic                   keep;

  // Both buffer halves in use means the current half still belongs to the back end.
  assign in_ready = (busy_r != 2'd2);
  assign take     = in_valid & in_ready;
  assign keep     = (rows_r < CNT_W'(MAX_ROWS));

  // Running column sums with this word's samples added.
  for (genvar l = 0; l < LANES; l++) begin : g_sum
    assign sums_add[l*SUM_W +: SUM_W] = sums_r[l*SUM_W +: SUM_W]
                                      + SUM_W'(signed'(in_data[l*DATA_W +: DATA_W]));
  end

  // Row writes go into the current half at the next free row.
  assign wr_en   = take & keep;
  assign wr_addr = {bank_r, rows_r[ROW_W-1:0]};
  assign wr_data = in_data[LANES*DATA_W-1:0];

  // A last word closes the group and passes its totals to the job queue.
  assign push     = take & in_last;
  assign job_sums = keep ? sums_add : sums_r;
  assign job_cnt  = keep ? rows_r + CNT_W'(1) : rows_r;
  assign job_ovf  = ovf_r | ~keep;
  assign job_bank = bank_r;

  // Accumulator and counter updates.
  always_comb begin
    rows_nxt = rows_r;
    sums_nxt = sums_r;
    ovf_nxt  = ovf_r;
    bank_nxt = bank_r;
    if (take) begin
      if (keep) begin
        rows_nxt = rows_r + CNT_W'(1);
        sums_nxt = sums_add;
      end else begin
        ovf_nxt = 1'b1;
      end
      if (in_last) begin
        rows_nxt = '0;
        sums_nxt = '0;
        ovf_nxt  = 1'b0;
        bank_nxt = ~bank_r;
      end
    end
    busy_nxt = busy_r + {1'b0, push} - {1'b0, grp_done};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
      sums_r <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
      busy_r <= 2'd0;
    end else begin
      rows_r <= rows_nxt;
      sums_r <= sums_nxt;
      ovf_r  <= ovf_nxt;
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// ===== hdl/gms_job_q.sv =====
`timescale 1ns / 1ps
// Two-entry queue of finished groups between the front and back ends of the
// group mean subtraction unit. Uses gms_pkg.
module gms_job_q #(
  parameter int W = 352
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data
);
  import gms_pkg::*;

  logic [W-1:0] ent_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = ent_r[rp_r];

endmodule

// ===== hdl/gms_back.sv =====
`timescale 1ns / 1ps
// Back end of the group mean subtraction unit: divides the column sums by the
// row count one quotient bit per cycle, then streams the buffered rows out with
// the means subtracted. Uses gms_pkg.
module gms_back #(
  parameter int LANES       = 9,
  parameter int SUM_W       = 38,
  parameter int CNT_W       = 7,
  parameter int AW          = 7,
  parameter int MAX_COLUMNS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              job_valid,
  output logic                              job_pop,
  input  logic [LANES*SUM_W-1:0]            job_sums,
  input  logic [CNT_W-1:0]                  job_cnt,
  input  logic                              job_ovf,
  input  logic                              job_bank,
  input  logic [gms_pkg::CFG_W-1:0]         cols,
  output logic                              rd_en,
  output logic [AW-1:0]                     rd_addr,
  input  logic [LANES*gms_pkg::DATA_W-1:0]  rd_data,
  output logic                              grp_done,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [LANES*gms_pkg::DEV_W-1:0]   out_dev,
  output gms_pkg::gms_flags_t               out_flags
);
  import gms_pkg::*;

  localparam int ROW_W  = AW - 1;
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [CNT_W-1:0]       rp_r, rp_nxt;
  logic                   rv_r, rv_nxt;
  logic                   ov_r, ov_nxt;
  logic                   rlast_r;
  logic                   olast_r;
  logic [CNT_W-1:0]       n_r;
  logic                   bank_r;
  logic                   ovf_r;
  logic [CFG_W-1:0]       act_r;
  logic [CFG_W-1:0]       act_w;
  logic [SUM_W-1:0]       quo_r   [LANES];
  logic [CNT_W-1:0]       rem_r   [LANES];
  logic [LANES-1:0]       neg_r;
  logic [SUM_W-1:0]       abs_w   [LANES];
  logic [CNT_W:0]         shift_w [LANES];
  logic [CNT_W:0]         sub_w   [LANES];
  logic [LANES-1:0]       fit_w;
  logic [LANES*DEV_W-1:0] dev_r, dev_w;
  logic                   adv;
  logic                   issue;

  // Read stage moves into the output register when that register is free.
  assign adv   = rv_r & (~ov_r | out_ready);
  assign issue = (state_r == ST_EMIT) && (rp_r != n_r) && (!rv_r || adv);

  assign rd_en   = issue;
  assign rd_addr = {bank_r, rp_r[ROW_W-1:0]};

  // Column count as seen by this group, held to the supported range.
  always_comb begin
    act_w = cols;
    if (cols == '0) begin
      act_w = CFG_W'(1);
    end else if (cols > CFG_W'(MAX_COLUMNS)) begin
      act_w = CFG_W'(MAX_COLUMNS);
    end
  end

  // Sum magnitudes and one restoring division step per lane.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      abs_w[l]   = job_sums[l*SUM_W + SUM_W - 1] ? -job_sums[l*SUM_W +: SUM_W]
                                                 :  job_sums[l*SUM_W +: SUM_W];
      shift_w[l] = {rem_r[l], quo_r[l][SUM_W-1]};
      sub_w[l]   = shift_w[l] - {1'b0, n_r};
      fit_w[l]   = (shift_w[l] >= {1'b0, n_r});
    end
  end

  // Deviations of the row in the read stage; unused columns give zero.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (l == 0 || CFG_W'(l - 1) < act_r) begin
        dev_w[l*DEV_W +: DEV_W] = DEV_W'(signed'(rd_data[l*DATA_W +: DATA_W]))
                                - quo_r[l][DEV_W-1:0];
      end else begin
        dev_w[l*DEV_W +: DEV_W] = '0;
      end
    end
  end

  // Sequencer: take a group, divide, fix signs, emit rows.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rp_nxt    = rp_r;
    rv_nxt    = rv_r;
    ov_nxt    = ov_r;
    job_pop   = 1'b0;
    grp_done  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        rp_nxt    = '0;
        rv_nxt    = 1'b0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (issue) begin
          rp_nxt = rp_r + CNT_W'(1);
        end
        rv_nxt = issue | (rv_r & ~adv);
        if (adv) begin
          ov_nxt = 1'b1;
        end else if (out_ready) begin
          ov_nxt = 1'b0;
        end
        if (ov_r && out_ready && olast_r) begin
          grp_done  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      rp_r    <= '0;
      rv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      rp_r    <= rp_nxt;
      rv_r    <= rv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Divider lanes and group context.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          n_r    <= job_cnt;
          bank_r <= job_bank;
          ovf_r  <= job_ovf;
          act_r  <= act_w;
          for (int l = 0; l < LANES; l++) begin
            quo_r[l] <= abs_w[l];
            rem_r[l] <= '0;
            neg_r[l] <= job_sums[l*SUM_W + SUM_W - 1];
          end
        end
      end
      ST_DIV: begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[l] <= fit_w[l] ? sub_w[l][CNT_W-1:0] : shift_w[l][CNT_W-1:0];
          quo_r[l] <= {quo_r[l][SUM_W-2:0], fit_w[l]};
        end
      end
      ST_SIGN: begin
        // Quotient magnitude becomes the mean, truncated toward zero.
        for (int l = 0; l < LANES; l++) begin
          quo_r[l] <= neg_r[l] ? -quo_r[l] : quo_r[l];
        end
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
    if (issue) begin
      rlast_r <= (rp_r + CNT_W'(1) == n_r);
    end
    if (adv) begin
      dev_r   <= dev_w;
      olast_r <= rlast_r;
    end
  end

  assign out_valid      = ov_r;
  assign out_dev        = dev_r;
  assign out_flags.last = olast_r;
  assign out_flags.ovf  = ovf_r;

endmodule

// ===== hdl/group_mean_subtraction_unit.sv =====
`timescale 1ns / 1ps
// Group mean subtraction unit: subtracts per-group column means from buffered rows.
// Top level; uses gms_pkg, gms_row_store, gms_front, gms_job_q and gms_back.
//
// Usage: rows of one group arrive on the in_ stream, one row per word, with
// in_tlast on the final row. The first MAX_ROWS rows are stored and added into
// per-column sums at one word per cycle while in_tready is high. On the last row
// the group's totals move through a two-entry job queue to the back end, which
// divides all nine sums in parallel (one quotient bit per cycle), fixes the
// signs in the ST_SIGN state and then streams every kept row on the out_ stream
// at one word per cycle while out_tready is high, with out_tlast on the final
// row and out_tuser set on every row of a group that lost rows to a full buffer.
// The row buffer has two halves, so the next group loads while the previous one
// is divided and emitted. in_tready drops while both halves hold groups that are
// not yet fully emitted. A stalled out_tready holds the output word and backs up
// the read stage; the front end keeps loading meanwhile.
// After reset no group is held and the column count register reads 8.
module group_mean_subtraction_unit #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: response_value, column_0 .. column_7 (32 bits each), lowest first
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [gms_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  // out_tdata: response_deviation, deviation_0 .. deviation_7 (33 bits each),
  // lowest first, zero padding above
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gms_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  // out_tuser: group_overflow
  output logic                            out_tuser,
  // cfg_data: columns_in_use
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gms_pkg::CFG_W-1:0]       cfg_data
);
  import gms_pkg::*;

  localparam int LANES = MAX_COLUMNS + 1;
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int AW    = ROW_W + 1;
  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam int SUM_W = DATA_W + ROW_W;
  localparam int JOB_W = LANES*SUM_W + CNT_W + 2;

  logic [CFG_W-1:0]       cols_r;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [LANES*DATA_W-1:0] wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [LANES*DATA_W-1:0] rd_data;
  logic                   push;
  logic [LANES*SUM_W-1:0] f_sums;
  logic [CNT_W-1:0]       f_cnt;
  logic                   f_ovf;
  logic                   f_bank;
  logic                   pop;
  logic                   head_valid;
  logic [JOB_W-1:0]       head_data;
  logic                   grp_done;
  logic [LANES*DEV_W-1:0] out_dev;
  gms_flags_t             out_flags;

  // Column count register; writes are always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= CFG_RESET;
    end else if (cfg_valid) begin
      cols_r <= cfg_data;
    end
  end

  gms_row_store #(
    .W  (LANES*DATA_W),
    .AW (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gms_front #(
    .MAX_ROWS (MAX_ROWS),
    .LANES    (LANES),
    .SUM_W    (SUM_W),
    .CNT_W    (CNT_W),
    .AW       (AW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .in_last  (in_tlast),
    .grp_done (grp_done),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .push     (push),
    .job_sums (f_sums),
    .job_cnt  (f_cnt),
    .job_ovf  (f_ovf),
    .job_bank (f_bank)
  );

  gms_job_q #(
    .W (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({f_ovf, f_bank, f_cnt, f_sums}),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  gms_back #(
    .LANES       (LANES),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W),
    .AW          (AW),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (head_valid),
    .job_pop   (pop),
    .job_sums  (head_data[LANES*SUM_W-1:0]),
    .job_cnt   (head_data[LANES*SUM_W +: CNT_W]),
    .job_ovf   (head_data[JOB_W-1]),
    .job_bank  (head_data[JOB_W-2]),
    .cols      (cols_r),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .grp_done  (grp_done),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_dev   (out_dev),
    .out_flags (out_flags)
  );

  assign out_tdata = OUT_TDATA_W'(out_dev);
  assign out_tlast = out_flags.last;
  assign out_tuser = out_flags.ovf;

endmodule

// ===== hdl/gms_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the group mean subtraction unit and the bind that
// attaches them to group_mean_subtraction_unit. Uses gms_pkg.
module gms_checker #(
  parameter int MAX_COLUMNS = 8
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gms_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser
);
  import gms_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [2:0] pend_r;
  logic       mid_r;
  logic       ovf_r;

  assign in_acc  = in_tvalid & in_tready;
  assign out_acc = out_tvalid & out_tready;

  // Groups closed at the input that have not been fully emitted yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
      mid_r  <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      pend_r <= pend_r + {2'b00, in_acc & in_tlast} - {2'b00, out_acc & out_tlast};
      if (out_acc) begin
        mid_r <= ~out_tlast;
        ovf_r <= out_tuser;
      end
    end
  end

  // No result word before its group was closed at the input.
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pend_r != 3'd0))
    else $error("result word with no closed group pending");

  // Two groups in flight fill both buffer halves.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r >= 3'd2) |-> !in_tready)
    else $error("input accepted while both buffer halves are busy");

  // The overflow flag is the same on every word of a group.
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && mid_r) |-> (out_tuser == ovf_r))
    else $error("overflow flag changed within a group");

  // The padding above the built columns stays zero.
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata >> (DEV_W*(MAX_COLUMNS + 1))) == '0))
    else $error("nonzero bits above the built columns");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("result word changed while stalled");

endmodule

bind group_mean_subtraction_unit gms_checker #(
  .MAX_COLUMNS (MAX_COLUMNS)
) u_gms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
